// ===== rtl/core/ic3_pkg.sv =====
package ic3_pkg;

  localparam logic [8:0] MaxWidth  = 9'd256;
  localparam logic [8:0] MaxHeight = 9'd256;
  localparam int KernelMax = 3;
  localparam int AccW      = 30;
  localparam int ProdW     = 25;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_BORDER = 3'd2;
  localparam logic [2:0] CFG_SHAPE  = 3'd3;
  localparam logic [2:0] CFG_COEF0  = 3'd4;
  localparam logic [2:0] CFG_COEF1  = 3'd5;
  localparam logic [2:0] CFG_COEF2  = 3'd6;

  localparam logic [1:0] BORDER_CLAMP = 2'd0;
  localparam logic [1:0] BORDER_ZERO  = 2'd1;
  localparam logic [1:0] BORDER_WRAP  = 2'd2;

  typedef enum logic {
    FE_RUN,
    FE_DIV
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_TAPS,
    BE_DRAIN,
    BE_DONE
  } be_state_e;

  // effective configuration seen by the front and back
  typedef struct packed {
    logic [8:0]       width;
    logic [8:0]       height;
    logic [1:0]       border;
    logic [7:0]       shape;
    logic [2:0][47:0] coef;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  pixel;
    logic [15:0] addr;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        last;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] idx;
  } tap_coord_t;

  function automatic logic [8:0] eff_dim(input logic [8:0] v, input logic [8:0] vmax);
    logic [8:0] res;
    res = v;
    if (v == 9'd0) res = 9'd1;
    else if (v > vmax) res = vmax;
    return res;
  endfunction

  // map pos + ctr - k into 0..n-1 following the border mode
  function automatic tap_coord_t map_coord(input logic [7:0] pos, input logic [1:0] ctr,
                                           input logic [1:0] k, input logic [8:0] n,
                                           input logic [1:0] mode);
    logic signed [11:0] v;
    logic signed [11:0] ns;
    logic signed [11:0] p1;
    logic signed [11:0] p2;
    logic signed [11:0] m1;
    logic signed [11:0] m2;
    logic signed [11:0] m3;
    logic [8:0]         nm1;
    tap_coord_t         res;
    v   = $signed({4'b0, pos}) + $signed({10'b0, ctr}) - $signed({10'b0, k});
    ns  = $signed({3'b0, n});
    p1  = v + ns;
    p2  = p1 + ns;
    m1  = v - ns;
    m2  = m1 - ns;
    m3  = m2 - ns;
    nm1 = n - 9'd1;
    res.ok  = 1'b1;
    res.idx = '0;
    if (v >= 0 && v < ns) begin
      res.idx = v[7:0];
    end else begin
      case (mode)
        BORDER_CLAMP: res.idx = (v < 0) ? 8'd0 : nm1[7:0];
        BORDER_WRAP: begin
          if (v < 0) res.idx = (p1 >= 0) ? p1[7:0] : p2[7:0];
          else if (m1 < ns) res.idx = m1[7:0];
          else if (m2 < ns) res.idx = m2[7:0];
          else res.idx = m3[7:0];
        end
        default: res.ok = 1'b0;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/image_convolution_3x3_borders_unit.sv =====
// 3x3 convolution of an 8-bit grayscale frame with clamp, zero or wrap borders.
// Input channel (in_valid_i / in_stall_o, action_i, pixel_in_i): a load item
// writes pixel_in_i to the next raster position of the frame store; an emit
// item produces the next output pixel in raster order.
// Output channel (out_valid_o / out_stall_i): one item per emit, with
// frame_end_o set on the last pixel of the frame.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high,
// only while the block is idle.
// A load waits in the queue and is written to the store when the engine
// takes it; an emit's result leaves through the output register. Each emit
// occupies the tap engine for the cycle that takes it from the queue, nine
// taps read one after another from the single-port frame store, a
// read/multiply/accumulate drain and the output load.
// A load passes the engine as it is taken. A width write starts a
// position rebuild (serial divide) before the next item is taken.
// Reset clears the positions and loads the default single-tap kernel (zero
// borders, 256x256 frame); the frame store holds garbage until loaded.
// A stalled receiver holds the output register; up to two items queue in
// front of the engine before in_stall_o rises.
module image_convolution_3x3_borders_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_out_o,
  output logic        frame_end_o
);

  logic [8:0]  width_q;
  logic [8:0]  height_q;
  logic [1:0]  border_q;
  logic [7:0]  shape_q;
  logic [47:0] coef0_q;
  logic [47:0] coef1_q;
  logic [47:0] coef2_q;

  ic3_pkg::cfg_t cfg;
  ic3_pkg::job_t push_job;
  ic3_pkg::job_t pop_job;
  logic          width_wr;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      border_q <= ic3_pkg::BORDER_ZERO;
      shape_q  <= 8'd171;
      coef0_q  <= 48'd0;
      coef1_q  <= 48'd256;
      coef2_q  <= 48'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ic3_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[8:0];
        ic3_pkg::CFG_HEIGHT: height_q <= cfg_data_i[8:0];
        ic3_pkg::CFG_BORDER: border_q <= cfg_data_i[1:0];
        ic3_pkg::CFG_SHAPE:  shape_q  <= cfg_data_i[7:0];
        ic3_pkg::CFG_COEF0:  coef0_q  <= cfg_data_i;
        ic3_pkg::CFG_COEF1:  coef1_q  <= cfg_data_i;
        ic3_pkg::CFG_COEF2:  coef2_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_wr = cfg_we_i && (cfg_idx_i == ic3_pkg::CFG_WIDTH);

  always_comb begin
    cfg.width   = ic3_pkg::eff_dim(width_q, ic3_pkg::MaxWidth);
    cfg.height  = ic3_pkg::eff_dim(height_q, ic3_pkg::MaxHeight);
    cfg.border  = border_q;
    cfg.shape   = shape_q;
    cfg.coef[0] = coef0_q;
    cfg.coef[1] = coef1_q;
    cfg.coef[2] = coef2_q;
  end

  ic3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .width_wr_i (width_wr),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .pixel_in_i (pixel_in_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  ic3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (empty)
  );

  ic3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (pop_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== rtl/core/ic3_fifo.sv =====
module ic3_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ic3_pkg::job_t   data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ic3_pkg::job_t   data_o,
  output logic            empty_o
);

  ic3_pkg::job_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("item pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("item popped from empty queue");
`endif

endmodule

// ===== rtl/core/ic3_front.sv =====
module ic3_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ic3_pkg::cfg_t   cfg_i,
  input  logic            width_wr_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            action_i,
  input  logic [7:0]      pixel_in_i,
  output logic            push_o,
  output ic3_pkg::job_t   job_o,
  input  logic            full_i
);

  ic3_pkg::fe_state_e state_q, state_d;
  logic [15:0] load_pos_q, load_pos_d;
  logic [15:0] emit_pos_q, emit_pos_d;
  logic [7:0]  ex_q, ex_d;
  logic [7:0]  ey_q, ey_d;
  logic        sync_q, sync_d;
  logic [8:0]  div_rem_q, div_rem_d;
  logic [15:0] div_quo_q, div_quo_d;
  logic [3:0]  div_cnt_q, div_cnt_d;

  logic [17:0] npix;
  logic [15:0] load_addr;
  logic [16:0] load_nxt;
  logic        emit_wrap;
  logic [15:0] e_pos;
  logic [7:0]  e_x;
  logic [7:0]  e_y;
  logic        e_last;
  logic [8:0]  x_inc;
  logic [9:0]  div_sh;
  logic        div_ge;
  logic [9:0]  div_sub;

  assign npix      = {9'b0, cfg_i.width} * {9'b0, cfg_i.height};
  assign load_addr = ({2'b0, load_pos_q} >= npix) ? 16'd0 : load_pos_q;
  assign load_nxt  = {1'b0, load_addr} + 17'd1;
  assign emit_wrap = ({2'b0, emit_pos_q} >= npix);
  assign e_pos     = emit_wrap ? 16'd0 : emit_pos_q;
  assign e_x       = emit_wrap ? 8'd0 : ex_q;
  assign e_y       = emit_wrap ? 8'd0 : ey_q;
  assign e_last    = ({2'b0, e_pos} == (npix - 18'd1));
  assign x_inc     = {1'b0, e_x} + 9'd1;

  assign div_sh  = {div_rem_q, div_quo_q[15]};
  assign div_ge  = (div_sh >= {1'b0, cfg_i.width});
  assign div_sub = div_sh - {1'b0, cfg_i.width};

  assign in_stall_o = (state_q != ic3_pkg::FE_RUN) || !sync_q || full_i;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    job_o.emit  = action_i;
    job_o.pixel = pixel_in_i;
    job_o.addr  = load_addr;
    job_o.x     = e_x;
    job_o.y     = e_y;
    job_o.last  = e_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ic3_pkg::FE_RUN;
      load_pos_q <= '0;
      emit_pos_q <= '0;
      ex_q       <= '0;
      ey_q       <= '0;
      sync_q     <= 1'b1;
      div_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      load_pos_q <= load_pos_d;
      emit_pos_q <= emit_pos_d;
      ex_q       <= ex_d;
      ey_q       <= ey_d;
      sync_q     <= sync_d;
      div_cnt_q  <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
  end

  always_comb begin
    state_d    = state_q;
    load_pos_d = load_pos_q;
    emit_pos_d = emit_pos_q;
    ex_d       = ex_q;
    ey_d       = ey_q;
    sync_d     = sync_q;
    div_rem_d  = div_rem_q;
    div_quo_d  = div_quo_q;
    div_cnt_d  = div_cnt_q;
    unique case (state_q)
      ic3_pkg::FE_RUN: begin
        if (!sync_q) begin
          // rebuild column and row of the emit position for the new width
          div_rem_d = '0;
          div_quo_d = emit_pos_q;
          div_cnt_d = 4'd15;
          state_d   = ic3_pkg::FE_DIV;
        end else if (push_o) begin
          if (!action_i) begin
            load_pos_d = ({1'b0, load_nxt} >= npix) ? 16'd0 : load_nxt[15:0];
          end else if (e_last) begin
            emit_pos_d = '0;
            ex_d       = '0;
            ey_d       = '0;
          end else begin
            emit_pos_d = e_pos + 16'd1;
            if (x_inc == cfg_i.width) begin
              ex_d = '0;
              ey_d = e_y + 8'd1;
            end else begin
              ex_d = x_inc[7:0];
              ey_d = e_y;
            end
          end
        end
      end
      ic3_pkg::FE_DIV: begin
        div_rem_d = div_ge ? div_sub[8:0] : div_sh[8:0];
        div_quo_d = {div_quo_q[14:0], div_ge};
        div_cnt_d = div_cnt_q - 4'd1;
        if (div_cnt_q == 4'd0) begin
          ex_d    = div_rem_d[7:0];
          ey_d    = div_quo_d[7:0];
          sync_d  = 1'b1;
          state_d = ic3_pkg::FE_RUN;
        end
      end
      default: state_d = ic3_pkg::FE_RUN;
    endcase
    if (width_wr_i) begin
      sync_d  = 1'b0;
      state_d = ic3_pkg::FE_RUN;
    end
  end

`ifndef SYNTHESIS
  a_div_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ic3_pkg::FE_DIV) |-> !push_o) else $error("item taken during position rebuild");
`endif

endmodule

// ===== rtl/core/ic3_back.sv =====
module ic3_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ic3_pkg::cfg_t   cfg_i,
  input  ic3_pkg::job_t   job_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      pixel_out_o,
  output logic            frame_end_o
);

  ic3_pkg::be_state_e state_q, state_d;
  logic [1:0]  r_q, r_d;
  logic [1:0]  c_q, c_d;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic        last_q;

  logic        a_vld_q, a_en_q;
  logic [15:0] a_addr_q;
  logic signed [15:0] a_coef_q;
  logic        b_vld_q, b_en_q;
  logic [7:0]  b_pix_q;
  logic signed [15:0] b_coef_q;
  logic        c_vld_q;
  logic signed [ic3_pkg::ProdW-1:0] c_prod_q;
  logic signed [ic3_pkg::AccW-1:0]  acc_q;

  logic        out_valid_q;
  logic [7:0]  out_pix_q;
  logic        out_end_q;

  logic [7:0]  mem [65536];

  ic3_pkg::tap_coord_t ty, tx;
  logic        issue;
  logic        tap_en;
  logic [16:0] tap_addr;
  logic [15:0] tap_coef;
  logic        take_emit;
  logic        mem_we;
  logic        out_load;
  logic        pipe_busy;
  logic signed [ic3_pkg::AccW-1:0] rnd;
  logic [7:0]  pix_res;

  assign ty = ic3_pkg::map_coord(y_q, cfg_i.shape[5:4], r_q, cfg_i.height, cfg_i.border);
  assign tx = ic3_pkg::map_coord(x_q, cfg_i.shape[7:6], c_q, cfg_i.width, cfg_i.border);
  assign tap_en = ty.ok && tx.ok && (r_q <= cfg_i.shape[1:0]) && (c_q <= cfg_i.shape[3:2]);
  assign tap_addr = 17'({9'b0, ty.idx} * {8'b0, cfg_i.width}) + {9'b0, tx.idx};
  assign tap_coef = cfg_i.coef[r_q][{c_q, 4'b0} +: 16];

  assign pop_o     = (state_q == ic3_pkg::BE_IDLE) && !empty_i;
  assign take_emit = pop_o && job_i.emit;
  assign mem_we    = pop_o && !job_i.emit;
  assign issue     = (state_q == ic3_pkg::BE_TAPS);
  assign pipe_busy = a_vld_q || b_vld_q || c_vld_q;
  assign out_load  = (state_q == ic3_pkg::BE_DONE) && (!out_valid_q || !out_stall_i);

  // round half away from zero; negative sums clamp to zero anyway
  assign rnd = acc_q + ic3_pkg::AccW'(128);
  always_comb begin
    if (acc_q < 0) pix_res = 8'd0;
    else if (|rnd[ic3_pkg::AccW-1:16]) pix_res = 8'd255;
    else pix_res = rnd[15:8];
  end

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    unique case (state_q)
      ic3_pkg::BE_IDLE: begin
        if (take_emit) begin
          r_d     = '0;
          c_d     = '0;
          state_d = ic3_pkg::BE_TAPS;
        end
      end
      ic3_pkg::BE_TAPS: begin
        if (c_q == 2'd2) begin
          c_d = '0;
          if (r_q == 2'd2) state_d = ic3_pkg::BE_DRAIN;
          else r_d = r_q + 2'd1;
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      ic3_pkg::BE_DRAIN: begin
        if (!pipe_busy) state_d = ic3_pkg::BE_DONE;
      end
      ic3_pkg::BE_DONE: begin
        if (out_load) state_d = ic3_pkg::BE_IDLE;
      end
      default: state_d = ic3_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ic3_pkg::BE_IDLE;
      r_q         <= '0;
      c_q         <= '0;
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      a_vld_q <= issue;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_emit) begin
      x_q    <= job_i.x;
      y_q    <= job_i.y;
      last_q <= job_i.last;
      acc_q  <= '0;
    end else if (c_vld_q) begin
      acc_q <= acc_q + ic3_pkg::AccW'(c_prod_q);
    end
    a_en_q   <= tap_en;
    a_addr_q <= tap_addr[15:0];
    a_coef_q <= $signed(tap_coef);
    b_en_q   <= a_en_q;
    b_coef_q <= a_coef_q;
    if (b_en_q) c_prod_q <= b_coef_q * $signed({1'b0, b_pix_q});
    else c_prod_q <= '0;
    if (out_load) begin
      out_pix_q <= pix_res;
      out_end_q <= last_q;
    end
  end

  // single-port frame store: loads write only while the tap pipeline is empty
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[job_i.addr] <= job_i.pixel;
    else if (a_vld_q) b_pix_q <= mem[a_addr_q];
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign frame_end_o = out_end_q;

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ic3_pkg::BE_IDLE) |-> !pipe_busy) else $error("tap pipeline busy while idle");
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ic3_pkg::BE_DONE) |-> !pipe_busy) else $error("result taken before last tap");
`endif

endmodule
